>>> rtl/mstk_pkg.sv
// Package with the payload types, state codes and field widths of the spanning tree block.
package mstk_pkg;

	localparam int unsigned VtxW   = 5;
	localparam int unsigned WgtW   = 16;
	localparam int unsigned SumW   = 21;
	localparam int unsigned VcntW  = 6;
	localparam logic [SumW-1:0] SumMax = '1;

	localparam logic [VcntW-1:0] VcntReset = 6'd32;
	localparam logic RegVcnt = 1'b0;

	typedef struct packed {
		logic [VtxW-1:0] edge_from;
		logic [VtxW-1:0] edge_to;
		logic [WgtW-1:0] edge_weight;
		logic            last_edge;
	} edge_req_t;

	typedef struct packed {
		logic [VtxW-1:0] tree_from;
		logic [VtxW-1:0] tree_to;
		logic [WgtW-1:0] tree_weight;
		logic [SumW-1:0] total_weight;
		logic            spanning;
		logic            overflow;
		logic            last_result;
	} tree_rsp_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT,
		ST_SRCH,
		ST_CHK,
		ST_COLA,
		ST_COLB,
		ST_EMIT,
		ST_RCL,
		ST_SUMM
	} state_t;

endpackage

>>> rtl/mstk_ram.sv
// Generic single write port, single read port RAM with registered read data.
module mstk_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/minimum_spanning_tree_kruskal.sv
// Kruskal minimum spanning tree: edge store, sorted scan sequencer and color table.
// Loading takes one edge request per cycle. After the last edge, an init pass seeds the colors,
// then each edge examined in weight order costs a search pass and the CHK, COLA and COLB color
// steps; a tree edge adds an emit step and a recolor pass. If the edges run out, one more
// search pass finds nothing; the summary state ends the run, which blocks the input.
// Reset clears counters and flags and sets vertex_count to 32; memories stay undefined.
module minimum_spanning_tree_kruskal
	import mstk_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = 32,
	parameter int unsigned MAX_EDGES    = 512
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  edge_req_t       in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output tree_rsp_t       out_data,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	localparam int unsigned EW = $clog2(MAX_EDGES);
	localparam int unsigned NW = $clog2(MAX_EDGES + 1);
	localparam int unsigned CW = $clog2(MAX_VERTICES);
	localparam int unsigned VW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned DW = 2 * VtxW + WgtW;

	// Configuration register; the only register sits at byte address zero.
	logic [VcntW-1:0] vcnt_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegVcnt) ? 32'(vcnt_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= VcntReset;
		end else if (psel && penable && pwrite && paddr[2] == RegVcnt) begin
			vcnt_q <= pwdata[VcntW-1:0];
		end
	end

	// Effective vertex count: zero acts as one, values above capacity are clamped.
	logic [VW-1:0] used_v;
	always_comb begin
		if (vcnt_q == '0) begin
			used_v = VW'(1);
		end else if (32'(vcnt_q) > 32'(MAX_VERTICES)) begin
			used_v = VW'(MAX_VERTICES);
		end else begin
			used_v = VW'(vcnt_q);
		end
	end

	state_t state_q, state_d;

	logic [NW-1:0]   edge_total_q;
	logic            dropped_q;
	logic [NW-1:0]   scan_q;
	logic            vld_s1;
	logic [EW-1:0]   idx_s1;
	logic            found_q;
	logic            have_prev_q;
	logic [WgtW-1:0] prev_w_q;
	logic [EW-1:0]   prev_idx_q;
	logic [VtxW-1:0] best_from_q, best_to_q;
	logic [WgtW-1:0] best_w_q;
	logic [EW-1:0]   best_idx_q;
	logic [CW-1:0]   ca_q, hi_q, lo_q;
	logic [SumW-1:0] sum_q;
	logic [VW-1:0]   tree_q;
	logic [VW-1:0]   vj_q;
	logic [CW-1:0]   vj_s1;
	logic            cvld_s1;
	logic            out_valid_q;
	tree_rsp_t       out_q;

	// Edge memory.
	logic            ewe;
	logic [EW-1:0]   eraddr;
	logic [DW-1:0]   erdata;
	logic [VtxW-1:0] rd_from, rd_to;
	logic [WgtW-1:0] rd_w;

	// Color table.
	logic            cwe;
	logic [CW-1:0]   cwaddr, craddr, cwdata, crdata;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic in_acc, drop_edge;
	assign in_acc    = in_valid && in_ready;
	assign drop_edge = (32'(in_data.edge_from) >= 32'(used_v)) ||
		(32'(in_data.edge_to) >= 32'(used_v)) || (32'(edge_total_q) >= 32'(MAX_EDGES));
	assign ewe = in_acc && !drop_edge;

	mstk_ram #(.WIDTH(DW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (ewe),
		.waddr (edge_total_q[EW-1:0]),
		.wdata ({in_data.edge_from, in_data.edge_to, in_data.edge_weight}),
		.raddr (eraddr),
		.rdata (erdata)
	);

	assign {rd_from, rd_to, rd_w} = erdata;

	mstk_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_color_ram (
		.clk   (clk),
		.we    (cwe),
		.waddr (cwaddr),
		.wdata (cwdata),
		.raddr (craddr),
		.rdata (crdata)
	);

	// Search compare: the candidate must follow the previous pick in (weight, index)
	// order and beat the best found so far in this pass. The scan runs in index order,
	// so among equal weights the first one seen wins.
	logic after_prev, better, cand_ok;
	assign after_prev = !have_prev_q || (rd_w > prev_w_q) ||
		(rd_w == prev_w_q && idx_s1 > prev_idx_q);
	assign better  = !found_q || (rd_w < best_w_q);
	assign cand_ok = vld_s1 && after_prev && better;

	logic scan_issue, scan_done;
	assign scan_issue = (scan_q < edge_total_q);
	assign scan_done  = !scan_issue && !vld_s1;

	logic best_oor;
	assign best_oor = (32'(best_from_q) >= 32'(used_v)) || (32'(best_to_q) >= 32'(used_v));

	logic more_edges;
	assign more_edges = (32'(tree_q) + 32'd1) < 32'(used_v);

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	logic [SumW:0] sum_wide;
	assign sum_wide = {1'b0, sum_q} + (SumW+1)'(best_w_q);

	logic rcl_issue;
	assign rcl_issue = (vj_q < used_v);

	// Next state and memory controls.
	always_comb begin
		state_d = state_q;
		eraddr  = scan_q[EW-1:0];
		cwe     = 1'b0;
		cwaddr  = vj_q[CW-1:0];
		cwdata  = vj_q[CW-1:0];
		craddr  = vj_q[CW-1:0];
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && in_data.last_edge) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				cwe = rcl_issue;
				if (!rcl_issue) begin
					state_d = more_edges ? ST_SRCH : ST_SUMM;
				end
			end
			ST_SRCH: begin
				if (scan_done) begin
					state_d = found_q ? ST_CHK : ST_SUMM;
				end
			end
			ST_CHK: begin
				craddr = CW'(best_from_q);
				state_d = best_oor ? ST_SRCH : ST_COLA;
			end
			ST_COLA: begin
				craddr = CW'(best_to_q);
				state_d = ST_COLB;
			end
			ST_COLB: begin
				state_d = (crdata == ca_q) ? ST_SRCH : ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_RCL;
				end
			end
			ST_RCL: begin
				cwaddr = vj_s1;
				cwdata = lo_q;
				cwe    = cvld_s1 && (crdata == hi_q);
				if (!rcl_issue && !cvld_s1) begin
					state_d = more_edges ? ST_SRCH : ST_SUMM;
				end
			end
			ST_SUMM: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			dropped_q    <= 1'b0;
			scan_q       <= '0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			have_prev_q  <= 1'b0;
			tree_q       <= '0;
			sum_q        <= '0;
			vj_q         <= '0;
			cvld_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			vld_s1  <= 1'b0;
			cvld_s1 <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (drop_edge) begin
							dropped_q <= 1'b1;
						end else begin
							edge_total_q <= edge_total_q + NW'(1);
						end
					end
					vj_q        <= '0;
					scan_q      <= '0;
					found_q     <= 1'b0;
					have_prev_q <= 1'b0;
				end
				ST_INIT: begin
					if (rcl_issue) begin
						vj_q <= vj_q + VW'(1);
					end
				end
				ST_SRCH: begin
					if (scan_issue) begin
						scan_q <= scan_q + NW'(1);
						vld_s1 <= 1'b1;
					end
					if (cand_ok) begin
						found_q <= 1'b1;
					end
				end
				ST_CHK: begin
					have_prev_q <= 1'b1;
					scan_q      <= '0;
					found_q     <= 1'b0;
				end
				ST_COLB: begin
					if (crdata != ca_q) begin
						sum_q <= sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						tree_q      <= tree_q + VW'(1);
						vj_q        <= '0;
					end
				end
				ST_RCL: begin
					if (rcl_issue) begin
						vj_q    <= vj_q + VW'(1);
						cvld_s1 <= 1'b1;
					end
				end
				ST_SUMM: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						edge_total_q <= '0;
						dropped_q    <= 1'b0;
						tree_q       <= '0;
						sum_q        <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[EW-1:0];
		vj_s1  <= vj_q[CW-1:0];
		if (state_q == ST_SRCH && cand_ok) begin
			best_from_q <= rd_from;
			best_to_q   <= rd_to;
			best_w_q    <= rd_w;
			best_idx_q  <= idx_s1;
		end
		if (state_q == ST_CHK) begin
			prev_w_q   <= best_w_q;
			prev_idx_q <= best_idx_q;
		end
		if (state_q == ST_COLA) begin
			ca_q <= crdata;
		end
		if (state_q == ST_COLB) begin
			hi_q <= (ca_q > crdata) ? ca_q : crdata;
			lo_q <= (ca_q > crdata) ? crdata : ca_q;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_q.tree_from    <= best_from_q;
			out_q.tree_to      <= best_to_q;
			out_q.tree_weight  <= best_w_q;
			out_q.total_weight <= sum_q;
			out_q.spanning     <= 1'b0;
			out_q.overflow     <= dropped_q;
			out_q.last_result  <= 1'b0;
		end else if (state_q == ST_SUMM && out_free) begin
			out_q.tree_from    <= '0;
			out_q.tree_to      <= '0;
			out_q.tree_weight  <= '0;
			out_q.total_weight <= sum_q;
			out_q.spanning     <= (32'(tree_q) + 32'd1) == 32'(used_v);
			out_q.overflow     <= dropped_q;
			out_q.last_result  <= 1'b1;
		end
	end

endmodule
